// ===== hdl/rmie_pkg.sv =====
package rmie_pkg;

  localparam int REG_COUNT_DEF  = 256;
  localparam int LINE_COUNT_DEF = 1024;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int FUNC_W   = 4;
  localparam int MODE_W   = 2;
  localparam int OPND_W   = 32;
  localparam int LINE_W   = 10;
  localparam int STATUS_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    OP_LOAD  = 4'd0,
    OP_STORE = 4'd1,
    OP_ADD   = 4'd2,
    OP_SUB   = 4'd3,
    OP_MULT  = 4'd4,
    OP_DIV   = 4'd5,
    OP_READ  = 4'd6,
    OP_WRITE = 4'd7,
    OP_JUMP  = 4'd8,
    OP_JGTZ  = 4'd9,
    OP_JZERO = 4'd10,
    OP_HALT  = 4'd11
  } func_t;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_IMM  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DIR  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_IND  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OPCODE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ADDR    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MODE    = 3'd4;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_RD1, S_RD1W, S_RD2, S_RD2W, S_EXEC,
    S_DCHK, S_DIV, S_DIVFIN, S_DONE, S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_step;    // write zero at clear pointer
    logic capture;     // latch the incoming request
    logic rd_op;       // read register at operand address
    logic rd_ind;      // read register at address from first read
    logic exec;        // compute operand value, status and next line
    logic div_start;
    logic div_step;
    logic div_fin;
    logic commit;      // write back and update line / flag
    logic out_load;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic need_rd1;
    logic need_rd2;
    logic need_div;
    logic div_last;
  } stat_t;

endpackage

// ===== hdl/rmie_if.sv =====
interface rmie_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  func;
  logic [1:0]  mode;
  logic signed [31:0] operand;
  logic signed [31:0] tape_value;
  modport source (output valid, func, mode, operand, tape_value, input ready);
  modport sink (input valid, func, mode, operand, tape_value, output ready);
endinterface

interface rmie_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  next_line;
  logic        tape_write_valid;
  logic signed [31:0] tape_write_value;
  logic        tape_read_used;
  logic        is_halted;
  logic [2:0]  status;
  modport source (output valid, next_line, tape_write_valid, tape_write_value,
                  tape_read_used, is_halted, status, input ready);
  modport sink (input valid, next_line, tape_write_valid, tape_write_value,
                tape_read_used, is_halted, status, output ready);
endinterface

// ===== hdl/ram_machine_instruction_executor.sv =====
// flow: capture, decode, then a registered read of the operand register for a direct operand
// and a second for an indirect one, execute, divide for div, commit and result register
// one instruction at a time: no new request is taken until the result has been accepted,
// so a result stall holds off the next request
// reset: synchronous rst; afterwards the register file is cleared entry by entry, no request taken
module ram_machine_instruction_executor import rmie_pkg::*; #(
  parameter int REG_COUNT  = REG_COUNT_DEF,
  parameter int LINE_COUNT = LINE_COUNT_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic clk,
  input logic rst,
  rmie_in_if.sink    in_ch,
  rmie_out_if.source out_ch
);

  ctrl_t ctl;
  stat_t st;

  rmie_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .st, .ctl
  );

  rmie_dp #(.REG_COUNT(REG_COUNT), .LINE_COUNT(LINE_COUNT), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk, .rst, .ctl, .st,
    .in_func(in_ch.func), .in_mode(in_ch.mode),
    .in_operand(in_ch.operand), .in_tape(in_ch.tape_value),
    .o_next_line(out_ch.next_line), .o_wvalid(out_ch.tape_write_valid),
    .o_wvalue(out_ch.tape_write_value), .o_rused(out_ch.tape_read_used),
    .o_halted(out_ch.is_halted), .o_status(out_ch.status)
  );

endmodule

// ===== hdl/rmie_ctrl.sv =====
module rmie_ctrl import rmie_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t st,
  output ctrl_t ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (st.clr_last) state_next = S_IDLE;
      S_IDLE:   if (in_valid) state_next = S_DECODE;
      S_DECODE: state_next = st.need_rd1 ? S_RD1 : S_EXEC;
      S_RD1:    state_next = S_RD1W;
      S_RD1W:   state_next = st.need_rd2 ? S_RD2 : S_EXEC;
      S_RD2:    state_next = S_RD2W;
      S_RD2W:   state_next = S_EXEC;
      S_EXEC:   state_next = S_DCHK;
      S_DCHK:   state_next = st.need_div ? S_DIV : S_DONE;
      S_DIV:    if (st.div_last) state_next = S_DIVFIN;
      S_DIVFIN: state_next = S_DONE;
      S_DONE:   state_next = S_OUT;
      S_OUT:    if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_CLEAR:  ctl.clr_step = 1'b1;
      S_IDLE:   begin in_ready = 1'b1; ctl.capture = in_valid; end
      S_RD1:    ctl.rd_op = 1'b1;
      S_RD2:    ctl.rd_ind = 1'b1;
      S_EXEC:   ctl.exec = 1'b1;
      S_DCHK:   ctl.div_start = st.need_div;
      S_DIV:    ctl.div_step = 1'b1;
      S_DIVFIN: ctl.div_fin = 1'b1;
      S_DONE:   begin ctl.commit = 1'b1; ctl.out_load = 1'b1; end
      S_OUT:    out_valid = 1'b1;
      default:  ;
    endcase
  end

endmodule

// ===== hdl/rmie_dp.sv =====
module rmie_dp import rmie_pkg::*; #(
  parameter int REG_COUNT  = REG_COUNT_DEF,
  parameter int LINE_COUNT = LINE_COUNT_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  ctrl_t ctl,
  output stat_t st,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [OPND_W-1:0] in_operand,
  input  logic [OPND_W-1:0] in_tape,
  output logic [LINE_W-1:0] o_next_line,
  output logic o_wvalid,
  output logic [OPND_W-1:0] o_wvalue,
  output logic o_rused,
  output logic o_halted,
  output logic [STATUS_W-1:0] o_status
);

  localparam int AW  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int LW  = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
  localparam int DW  = DATA_WIDTH;
  localparam int CW  = $clog2(DW + 1);
  localparam logic [AW:0] REG_LAST = (AW + 1)'(REG_COUNT - 1);
  localparam logic [LW:0] LINE_MAX = (LW + 1)'(LINE_COUNT - 1);

  // register file memory
  logic [DW-1:0] mem [REG_COUNT];
  logic [AW-1:0] clr_ptr;
  logic [DW-1:0] acc;      // accumulator copy, register 0
  logic [DW-1:0] rdata;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  // captured request
  logic [FUNC_W-1:0] func;
  logic [MODE_W-1:0] mode;
  logic [OPND_W-1:0] opnd;
  logic [DW-1:0]     tape;
  logic [LW-1:0]     pline;
  logic              halt;

  // decode results
  logic [AW-1:0]       idx;
  logic [DW-1:0]       val;
  logic [STATUS_W-1:0] status;
  logic [DW-1:0]       res;
  logic                wb_acc, wb_idx;
  logic [LW-1:0]       nline;

  always_ff @(posedge clk) begin
    if (rd_en) rdata <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) clr_ptr <= '0;
    else if (ctl.clr_step) clr_ptr <= clr_ptr + AW'(1);
  end
  assign st.clr_last = ({1'b0, clr_ptr} == REG_LAST);

  // request capture
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      func <= in_func;
      mode <= in_mode;
      opnd <= in_operand;
      tape <= DW'($signed(in_tape));
    end
  end

  // operand address checks
  logic op_ok, ind_ok, no_imm, is_data, mode_bad;
  assign op_ok  = !opnd[OPND_W-1] && ({{(AW+1){1'b0}}, opnd} < (OPND_W+AW+1)'(REG_COUNT));
  assign ind_ok = !rdata[DW-1] && ({{(AW+1){1'b0}}, rdata} < (DW+AW+1)'(REG_COUNT));
  assign no_imm = (func == OP_STORE) || (func == OP_READ);
  assign is_data = (func <= OP_WRITE);
  assign mode_bad = (mode == MODE_NONE) || (no_imm && mode == MODE_IMM);
  assign st.need_rd1 = !halt && is_data && !mode_bad && mode != MODE_IMM && op_ok;
  assign st.need_rd2 = (mode == MODE_IND) && ind_ok;

  // register read port
  always_comb begin
    rd_en = ctl.rd_op || ctl.rd_ind;
    rd_addr = ctl.rd_ind ? rdata[AW-1:0] : opnd[AW-1:0];
  end

  // address of the indirect target, held from the first read
  logic [AW-1:0] ind_addr;
  always_ff @(posedge clk) if (ctl.rd_ind) ind_addr <= rdata[AW-1:0];

  // indirect pointer was in range and its target got read
  logic ind_hit;
  always_ff @(posedge clk) begin
    if (ctl.capture) ind_hit <= 1'b0;
    else if (ctl.rd_ind) ind_hit <= 1'b1;
  end

  // divider, restoring, one quotient bit per cycle
  logic [DW-1:0] dv_rem, dv_q, dv_d;
  logic [CW-1:0] dv_cnt;
  logic          dv_neg;
  logic [DW:0]   dv_trial;
  assign dv_trial = {dv_rem[DW-2:0], dv_q[DW-1]} - {1'b0, dv_d};
  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      dv_rem <= '0;
      dv_q   <= acc[DW-1] ? -acc : acc;
      dv_d   <= val[DW-1] ? -val : val;
      dv_neg <= acc[DW-1] ^ val[DW-1];
      dv_cnt <= CW'(DW - 1);
    end else if (ctl.div_step) begin
      dv_cnt <= dv_cnt - CW'(1);
      if (!dv_trial[DW]) begin
        dv_rem <= dv_trial[DW-1:0];
        dv_q   <= {dv_q[DW-2:0], 1'b1};
      end else begin
        dv_rem <= {dv_rem[DW-2:0], dv_q[DW-1]};
        dv_q   <= {dv_q[DW-2:0], 1'b0};
      end
    end
  end
  assign st.div_last = (dv_cnt == '0);

  // multiply, registered operands product
  logic [DW-1:0] prod;
  always_ff @(posedge clk) prod <= acc * val;
  assign st.need_div = (func == OP_DIV) && (status == ST_OK) && !halt;

  // execute: status, operand value, next line
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      logic take;
      logic [LW-1:0] inc;
      inc = (pline == LW'(LINE_COUNT - 1)) ? '0 : pline + LW'(1);
      take = (func == OP_JUMP) || (func == OP_JGTZ && acc != '0 && !acc[DW-1]) ||
             (func == OP_JZERO && acc == '0);
      status <= ST_OK;
      nline <= inc;
      val <= DW'($signed(opnd));
      idx <= opnd[AW-1:0];
      if (halt) begin
        nline <= pline;
      end else if (is_data) begin
        if (mode_bad) status <= ST_MODE;
        else if (mode != MODE_IMM && !op_ok) status <= ST_ADDR;
        else if (mode == MODE_IND && !ind_hit) status <= ST_ADDR;
        else if (mode != MODE_IMM) begin
          if (mode == MODE_IND) idx <= ind_addr;
          val <= rdata;
        end
      end else if (func <= OP_JZERO) begin
        if (!take) nline <= inc;
        else if (opnd[OPND_W-1] || {1'b0, opnd} > (OPND_W+1)'(LINE_MAX)) status <= ST_ADDR;
        else nline <= opnd[LW-1:0];
      end else if (func == OP_HALT) begin
        nline <= pline;
      end else begin
        status <= ST_OPCODE;
      end
    end else if (ctl.div_start && val == '0) begin
      status <= ST_DIVZERO;
    end
  end

  // divide outcome with the quotient sign applied
  logic [DW-1:0] quot;
  always_ff @(posedge clk) if (ctl.div_fin) quot <= dv_neg ? -dv_q : dv_q;

  // commit: write back, line and halt update
  always_comb begin
    wb_acc = 1'b0;
    wb_idx = 1'b0;
    res = val;
    unique case (func)
      OP_LOAD:  begin wb_acc = 1'b1; res = val; end
      OP_STORE: begin wb_idx = 1'b1; res = acc; end
      OP_ADD:   begin wb_acc = 1'b1; res = acc + val; end
      OP_SUB:   begin wb_acc = 1'b1; res = acc - val; end
      OP_MULT:  begin wb_acc = 1'b1; res = prod; end
      OP_DIV:   begin wb_acc = 1'b1; res = quot; end
      OP_READ:  begin wb_idx = 1'b1; res = tape; end
      default:  ;
    endcase
    if (halt || !is_data || status != ST_OK) begin
      wb_acc = 1'b0;
      wb_idx = 1'b0;
    end
  end

  always_comb begin
    wr_en = ctl.clr_step || (ctl.commit && (wb_acc || wb_idx));
    wr_addr = ctl.clr_step ? clr_ptr : (wb_acc ? '0 : idx);
    wr_data = ctl.clr_step ? '0 : res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      pline <= '0;
      halt <= 1'b0;
    end else if (ctl.commit) begin
      if (wb_acc || (wb_idx && idx == '0)) acc <= res;
      if (!halt && status == ST_OK) begin
        pline <= nline;
        if (func == OP_HALT) halt <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      logic ok;
      ok = !halt && status == ST_OK;
      o_next_line <= LINE_W'(ok ? nline : pline);
      o_wvalid <= ok && func == OP_WRITE;
      o_wvalue <= (ok && func == OP_WRITE) ? OPND_W'($signed(val)) : '0;
      o_rused  <= ok && func == OP_READ;
      o_halted <= halt || (ok && func == OP_HALT);
      o_status <= halt ? ST_OK : status;
    end
  end

endmodule

// ===== dv/rmie_checker.sv =====
module rmie_checker import rmie_pkg::*; (
  input  logic clk,
  input  logic rst,
  rmie_in_if   in_ch,
  rmie_out_if  out_ch,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [LINE_W-1:0]   next_line;
    logic                tape_write_valid;
    logic [31:0]         tape_write_value;
    logic                tape_read_used;
    logic                is_halted;
    logic [STATUS_W-1:0] status;
  } exec_result_t;

  // machine state mirror
  logic [31:0]       regs [REG_COUNT_DEF];
  logic [LINE_W-1:0] cur_line;
  logic              halted;

  exec_result_t expected_results[$];

  function automatic logic addr_in_range(logic signed [31:0] a);
    return a >= 0 && a < REG_COUNT_DEF;
  endfunction

  // execute one instruction against the mirror state
  function automatic exec_result_t exec_instr(logic [3:0] fn, logic [1:0] md,
                                             logic signed [31:0] opnd,
                                             logic [31:0] tape);
    exec_result_t r;
    logic [LINE_W-1:0] nxt;
    logic [31:0] val, acc;
    int idx;
    logic take;
    r = '{default: '0};
    nxt = cur_line + 1'b1;
    val = '0;
    idx = 0;
    acc = regs[0];
    if (halted) begin
      nxt = cur_line;
    end else if (fn <= OP_WRITE) begin
      if (md == MODE_NONE || ((fn == OP_STORE || fn == OP_READ) && md == MODE_IMM)) begin
        r.status = ST_MODE;
      end else if (md == MODE_IMM) begin
        val = opnd;
      end else if (!addr_in_range(opnd)) begin
        r.status = ST_ADDR;
      end else begin
        idx = opnd;
        if (md == MODE_IND) begin
          if (!addr_in_range(regs[idx])) r.status = ST_ADDR;
          else idx = regs[idx];
        end
        if (r.status == ST_OK) val = regs[idx];
      end
      if (r.status == ST_OK) begin
        case (fn)
          OP_LOAD:  regs[0] = val;
          OP_STORE: regs[idx] = acc;
          OP_ADD:   regs[0] = acc + val;
          OP_SUB:   regs[0] = acc - val;
          OP_MULT:  regs[0] = acc * val;
          OP_DIV: begin
            if (val == 0) r.status = ST_DIVZERO;
            else if (acc == 32'h8000_0000 && val == 32'hffff_ffff) regs[0] = acc;
            else regs[0] = $signed(acc) / $signed(val);
          end
          OP_READ: begin
            regs[idx] = tape;
            r.tape_read_used = 1'b1;
          end
          default: begin
            r.tape_write_valid = 1'b1;
            r.tape_write_value = val;
          end
        endcase
      end
      if (r.status == ST_OK) cur_line = nxt;
      else nxt = cur_line;
    end else if (fn <= OP_JZERO) begin
      take = (fn == OP_JUMP) || (fn == OP_JGTZ && $signed(acc) > 0) ||
             (fn == OP_JZERO && acc == 0);
      if (take) begin
        if (opnd < 0 || opnd >= LINE_COUNT_DEF) begin
          r.status = ST_ADDR;
          nxt = cur_line;
        end else begin
          nxt = opnd[LINE_W-1:0];
        end
      end
      cur_line = nxt;
    end else if (fn == OP_HALT) begin
      halted = 1'b1;
      nxt = cur_line;
    end else begin
      r.status = ST_OPCODE;
      nxt = cur_line;
    end
    r.next_line = nxt;
    r.is_halted = halted;
    return r;
  endfunction

  // predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin
    exec_result_t e;
    if (rst) begin
      foreach (regs[i]) regs[i] = '0;
      cur_line = '0;
      halted = 1'b0;
      expected_results.delete();
      errors = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(exec_instr(in_ch.func, in_ch.mode, in_ch.operand,
                                              in_ch.tape_value));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: next_line %0d status %0d", out_ch.next_line,
                 out_ch.status);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_ch.next_line !== e.next_line) begin
            $error("next_line: expected %0d actual %0d", e.next_line, out_ch.next_line);
            errors++;
          end
          if (out_ch.tape_write_valid !== e.tape_write_valid) begin
            $error("tape_write_valid: expected %0d actual %0d", e.tape_write_valid,
                   out_ch.tape_write_valid);
            errors++;
          end
          if (out_ch.tape_write_value !== e.tape_write_value) begin
            $error("tape_write_value: expected %0h actual %0h", e.tape_write_value,
                   out_ch.tape_write_value);
            errors++;
          end
          if (out_ch.tape_read_used !== e.tape_read_used) begin
            $error("tape_read_used: expected %0d actual %0d", e.tape_read_used,
                   out_ch.tape_read_used);
            errors++;
          end
          if (out_ch.is_halted !== e.is_halted) begin
            $error("is_halted: expected %0d actual %0d", e.is_halted, out_ch.is_halted);
            errors++;
          end
          if (out_ch.status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, out_ch.status);
            errors++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== dv/tb_ram_machine_instruction_executor.sv =====
module tb_ram_machine_instruction_executor;
  import rmie_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_INSTRS = 1650;

  logic clk = 1'b0;
  logic rst;
  int   errors;
  int   pending;

  rmie_in_if  in_ch ();
  rmie_out_if out_ch ();

  ram_machine_instruction_executor dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  rmie_checker u_checker (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .errors (errors),
    .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // idle gap per request, with stretches of back-to-back traffic
  logic in_burst = 1'b0;

  task automatic send_instr(logic [3:0] fn, logic [1:0] md, logic [31:0] opnd,
                            logic [31:0] tape);
    int gap;
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= fn;
    in_ch.mode       <= md;
    in_ch.operand    <= opnd;
    in_ch.tape_value <= tape;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
  endtask

  // operand drawn to fit the addressing mode, mostly in range
  function automatic logic [31:0] pick_operand(logic [3:0] fn, logic [1:0] md);
    int r;
    r = $urandom_range(0, 99);
    if (fn >= OP_JUMP && fn <= OP_JZERO) begin
      if (r < 85) return $urandom_range(0, LINE_COUNT_DEF - 1);
      if (r < 92) return $urandom_range(LINE_COUNT_DEF, LINE_COUNT_DEF + 8);
      return $urandom;
    end
    if (md == MODE_IMM) begin
      if (r < 50) return $urandom_range(0, 300);
      if (r < 70) return -$urandom_range(1, 300);
      return $urandom;
    end
    if (r < 60) return $urandom_range(0, 15);
    if (r < 88) return $urandom_range(0, REG_COUNT_DEF - 1);
    if (r < 94) return $urandom_range(REG_COUNT_DEF, REG_COUNT_DEF + 40);
    return $urandom;
  endfunction

  task automatic send_random_instr();
    logic [3:0] fn;
    logic [1:0] md;
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) fn = 4'($urandom_range(12, 15));
    else if (r < 22) fn = OP_LOAD;
    else if (r < 38) fn = OP_STORE;
    else if (r < 82) fn = 4'($urandom_range(OP_ADD, OP_WRITE));
    else fn = 4'($urandom_range(OP_JUMP, OP_JZERO));
    r = $urandom_range(0, 99);
    if (r < 8) md = 2'($urandom_range(0, 3));
    else if (fn == OP_STORE || fn == OP_READ) md = (r < 60) ? MODE_DIR : MODE_IND;
    else md = (r < 50) ? MODE_IMM : (r < 80) ? MODE_DIR : MODE_IND;
    send_instr(fn, md, pick_operand(fn, md), $urandom);
  endtask

  // result side stalls
  initial begin
    int stall;
    logic out_burst;
    out_burst = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(negedge clk); while (!out_ch.valid);
      @(posedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    rst <= 1'b1;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= '0;
    in_ch.mode       <= '0;
    in_ch.operand    <= '0;
    in_ch.tape_value <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every operation but halt, error cases
    send_instr(OP_LOAD,  MODE_IMM,  32'h7fff_ffff, 32'h0);
    send_instr(OP_STORE, MODE_DIR,  32'd1, 32'h0);
    send_instr(OP_ADD,   MODE_IMM,  32'd1, 32'h0);
    send_instr(OP_DIV,   MODE_IMM,  32'hffff_ffff, 32'h0);
    send_instr(OP_DIV,   MODE_IMM,  32'h0, 32'h0);
    send_instr(OP_SUB,   MODE_DIR,  32'd1, 32'h0);
    send_instr(OP_MULT,  MODE_IMM,  32'hffff_fffd, 32'h0);
    send_instr(OP_STORE, MODE_IMM,  32'd3, 32'h0);
    send_instr(OP_LOAD,  MODE_NONE, 32'd3, 32'h0);
    send_instr(OP_READ,  MODE_DIR,  32'd255, 32'hffff_ffff);
    send_instr(OP_READ,  MODE_IMM,  32'd2, 32'h1234_5678);
    send_instr(OP_LOAD,  MODE_IMM,  32'd255, 32'h0);
    send_instr(OP_STORE, MODE_DIR,  32'd2, 32'h0);
    send_instr(OP_WRITE, MODE_IND,  32'd2, 32'h0);
    send_instr(OP_LOAD,  MODE_IND,  32'd1, 32'h0);
    send_instr(OP_LOAD,  MODE_DIR,  32'd256, 32'h0);
    send_instr(OP_LOAD,  MODE_DIR,  32'hffff_ffff, 32'h0);
    send_instr(OP_WRITE, MODE_IMM,  32'h8000_0000, 32'h0);
    send_instr(OP_JGTZ,  MODE_NONE, 32'd1023, 32'h0);
    send_instr(OP_JUMP,  MODE_NONE, 32'd1024, 32'h0);
    send_instr(OP_JUMP,  MODE_NONE, 32'h8000_0000, 32'h0);
    send_instr(OP_LOAD,  MODE_IMM,  32'h0, 32'h0);
    send_instr(OP_JGTZ,  MODE_NONE, 32'hffff_fffb, 32'h0);
    send_instr(OP_JZERO, MODE_NONE, 32'd10, 32'h0);
    send_instr(4'd12,    MODE_IMM,  32'd0, 32'h0);
    send_instr(4'd15,    MODE_IND,  32'd0, 32'h0);

    repeat (RANDOM_INSTRS) send_random_instr();

    // halt follows the random run since nothing leaves that state; the requests after it run halted
    send_instr(OP_HALT, MODE_NONE, 32'd0, 32'h0);
    repeat (5) send_random_instr();
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
